FILE: sv/set_associative_cache_lru_unit_macros.svh
// Assertion macros for the set-associative cache unit.
// Used by the back end module; no other dependencies.
`ifndef SET_ASSOCIATIVE_CACHE_LRU_UNIT_MACROS_SVH
`define SET_ASSOCIATIVE_CACHE_LRU_UNIT_MACROS_SVH
`ifndef SYNTH
`define SACL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("cache assertion failed");
`define SACL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cache assertion failed");
`else
`define SACL_ASSERT(lbl, prop)
`define SACL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/sacl_pkg.sv
// Shared types and constants of the set-associative cache unit.
// No dependencies.
`timescale 1ns / 1ps

package sacl_pkg;

	localparam int SET_BITS_DEF   = 6;
	localparam int WAYS_DEF       = 4;
	localparam int BLOCK_BITS_DEF = 5;
	localparam int WORD_BYTES     = 4;

	localparam logic [2:0] OP_LOOKUP = 3'd0;
	localparam logic [2:0] OP_VICTIM = 3'd1;
	localparam logic [2:0] OP_REFILL = 3'd2;
	localparam logic [2:0] OP_FILL   = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;
	localparam logic [2:0] OP_WRITE  = 3'd5;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_WB     = 2'd2;
	localparam logic [1:0] KIND_ACK    = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] address;
		logic [31:0] word_in;
		logic        victim_dirty;
		logic [31:0] now;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        hit;
		logic [1:0]  way;
		logic [31:0] word_out;
		logic [63:0] memory_address;
		logic        last;
	} out_t;

	typedef enum logic [2:0] {
		CMD_LOOKUP,
		CMD_VICTIM,
		CMD_REFILL,
		CMD_STORE,
		CMD_LOAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [63:0] address;
		logic [31:0] word;
		logic        dirty;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

FILE: sv/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sacl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/sacl_front.sv
// Front end: accepts request transfers, decodes the operation and queues commands.
// Depends on sacl_pkg.
`timescale 1ns / 1ps

module sacl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           request_valid,
	output logic           request_stall,
	input  sacl_pkg::in_t  request,
	output sacl_pkg::qhead_t head,
	input  logic           head_pop
);

	sacl_pkg::cmd_t entry_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           known;
	logic           push;
	sacl_pkg::cmd_t cmd;

	always_comb begin
		known        = 1'b1;
		cmd.kind     = sacl_pkg::CMD_LOOKUP;
		cmd.address  = request.address;
		cmd.word     = request.word_in;
		cmd.dirty    = request.victim_dirty;
		cmd.now      = request.now;
		case (request.op)
			sacl_pkg::OP_LOOKUP: cmd.kind = sacl_pkg::CMD_LOOKUP;
			sacl_pkg::OP_VICTIM: cmd.kind = sacl_pkg::CMD_VICTIM;
			sacl_pkg::OP_REFILL: cmd.kind = sacl_pkg::CMD_REFILL;
			sacl_pkg::OP_FILL:   cmd.kind = sacl_pkg::CMD_STORE;
			sacl_pkg::OP_WRITE:  cmd.kind = sacl_pkg::CMD_STORE;
			sacl_pkg::OP_READ:   cmd.kind = sacl_pkg::CMD_LOAD;
			default:             known = 1'b0;
		endcase
	end

	assign request_stall = (cnt_q == 2'd2);
	// Unknown operations are taken and dropped: they have no effect.
	assign push       = request_valid && !request_stall && known;
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (head_pop) begin
				rd_q <= !rd_q;
			end
			if (push && !head_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && head_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/sacl_back.sv
// Back end: tag, stamp and data memories, access line and the sequencer that
// executes queued commands and drives the response register.
// Depends on sacl_pkg, sacl_ram and the macros header.
`timescale 1ns / 1ps
`include "set_associative_cache_lru_unit_macros.svh"

module sacl_back #(
	parameter int SET_BITS   = sacl_pkg::SET_BITS_DEF,
	parameter int WAYS       = sacl_pkg::WAYS_DEF,
	parameter int BLOCK_BITS = sacl_pkg::BLOCK_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sacl_pkg::qhead_t head,
	output logic             head_pop,
	output logic             response_valid,
	input  logic             response_stall,
	output sacl_pkg::out_t   response
);

	localparam int NSETS      = 1 << SET_BITS;
	localparam int SET_W      = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WORD_BITS  = BLOCK_BITS - 2;
	localparam int LINE_WORDS = 1 << WORD_BITS;
	localparam int WORD_W     = (WORD_BITS > 0) ? WORD_BITS : 1;
	localparam int TAG_W      = 64 - SET_BITS - BLOCK_BITS;
	localparam int DATA_DEPTH = NSETS * WAYS * LINE_WORDS;
	localparam int DATA_AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EVAL, S_SCAN, S_REF, S_WB_RD, S_WB_OUT, S_FIN, S_LOAD
	} state_t;

	function automatic logic [SET_W-1:0] set_of(input logic [63:0] a);
		return SET_W'((a >> BLOCK_BITS) & 64'(NSETS - 1));
	endfunction

	function automatic logic [TAG_W-1:0] tag_of(input logic [63:0] a);
		return TAG_W'(a >> (SET_BITS + BLOCK_BITS));
	endfunction

	function automatic logic [WORD_W-1:0] off_of(input logic [63:0] a);
		return WORD_W'((a >> 2) & 64'(LINE_WORDS - 1));
	endfunction

	function automatic logic [DATA_AW-1:0] data_addr(input logic [SET_W-1:0] s,
			input logic [WAY_W-1:0] w, input logic [WORD_W-1:0] o);
		logic [31:0] line;
		line = 32'(s) * 32'(WAYS) + 32'(w);
		return DATA_AW'((line << WORD_BITS) | (32'(o) & 32'(LINE_WORDS - 1)));
	endfunction

	state_t            state_q, state_d;
	sacl_pkg::cmd_t    cmd_q;
	logic [SET_W-1:0]  acc_set_q, acc_set_d;
	logic [WAY_W-1:0]  acc_way_q, acc_way_d;
	logic [WAY_W-1:0]  idx_q, lru_q;
	logic [31:0]       best_q;
	logic [63:0]       wb_addr_q;
	logic [WORD_W-1:0] wi_q;
	logic [DATA_AW-1:0] clr_q;
	logic              out_valid_q;
	sacl_pkg::out_t    out_q;

	logic              out_free;
	logic              emit;
	sacl_pkg::out_t    emit_data;
	logic              hit;
	logic [WAY_W-1:0]  match;
	logic              cand;
	logic [WAY_W-1:0]  lru_fin;

	logic              tag_re, tag_wr, stamp_re, stamp_wr;
	logic [SET_W-1:0]  tag_raddr, tag_waddr, stamp_raddr, stamp_waddr;
	logic [WAY_W-1:0]  tag_wway, stamp_wway;
	logic [TAG_W:0]    tag_wdata;
	logic [31:0]       stamp_wdata;
	logic              clr_all;
	logic [TAG_W:0]    tag_row [WAYS];
	logic [31:0]       stamp_row [WAYS];

	logic              data_we, data_re;
	logic [DATA_AW-1:0] data_waddr, data_raddr;
	logic [31:0]       data_wdata, data_rdata;

	for (genvar w = 0; w < WAYS; w++) begin : g_way
		sacl_ram #(.WIDTH(TAG_W + 1), .DEPTH(NSETS), .AW(SET_W)) u_tag (
			.clk   (clk),
			.we    (clr_all || (tag_wr && tag_wway == WAY_W'(w))),
			.waddr (tag_waddr),
			.wdata (tag_wdata),
			.re    (tag_re),
			.raddr (tag_raddr),
			.rdata (tag_row[w])
		);
		sacl_ram #(.WIDTH(32), .DEPTH(NSETS), .AW(SET_W)) u_stamp (
			.clk   (clk),
			.we    (clr_all || (stamp_wr && stamp_wway == WAY_W'(w))),
			.waddr (stamp_waddr),
			.wdata (stamp_wdata),
			.re    (stamp_re),
			.raddr (stamp_raddr),
			.rdata (stamp_row[w])
		);
	end

	sacl_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH), .AW(DATA_AW)) u_data (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.re    (data_re),
		.raddr (data_raddr),
		.rdata (data_rdata)
	);

	assign out_free = !out_valid_q || !response_stall;

	// Last valid matching way wins.
	always_comb begin
		hit   = 1'b0;
		match = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (tag_row[w][TAG_W] && tag_row[w][TAG_W-1:0] == tag_of(cmd_q.address)) begin
				hit   = 1'b1;
				match = WAY_W'(w);
			end
		end
	end

	assign cand    = stamp_row[idx_q] < best_q;
	assign lru_fin = cand ? idx_q : lru_q;

	always_comb begin
		state_d     = state_q;
		acc_set_d   = acc_set_q;
		acc_way_d   = acc_way_q;
		head_pop    = 1'b0;
		emit        = 1'b0;
		emit_data   = '0;
		clr_all     = 1'b0;
		tag_re      = 1'b0;
		tag_wr      = 1'b0;
		tag_raddr   = acc_set_q;
		tag_waddr   = acc_set_q;
		tag_wway    = acc_way_q;
		tag_wdata   = {1'b1, tag_of(cmd_q.address)};
		stamp_re    = 1'b0;
		stamp_wr    = 1'b0;
		stamp_raddr = set_of(head.cmd.address);
		stamp_waddr = acc_set_q;
		stamp_wway  = acc_way_q;
		stamp_wdata = cmd_q.now;
		data_we     = 1'b0;
		data_re     = 1'b0;
		data_waddr  = data_addr(acc_set_q, acc_way_q, off_of(head.cmd.address));
		data_raddr  = data_addr(acc_set_q, acc_way_q, off_of(head.cmd.address));
		data_wdata  = head.cmd.word;
		case (state_q)
			S_CLEAR: begin
				clr_all     = 1'b1;
				data_we     = 1'b1;
				data_waddr  = clr_q;
				data_wdata  = '0;
				tag_waddr   = clr_q[SET_W-1:0];
				tag_wdata   = '0;
				stamp_waddr = clr_q[SET_W-1:0];
				stamp_wdata = '0;
				if (clr_q == DATA_AW'(DATA_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (head.valid && out_free) begin
					head_pop = 1'b1;
					case (head.cmd.kind)
						sacl_pkg::CMD_STORE: begin
							data_we        = 1'b1;
							emit           = 1'b1;
							emit_data.kind = sacl_pkg::KIND_ACK;
						end
						sacl_pkg::CMD_LOAD: begin
							data_re = 1'b1;
							state_d = S_LOAD;
						end
						default: begin
							tag_re    = 1'b1;
							stamp_re  = 1'b1;
							tag_raddr = set_of(head.cmd.address);
							state_d   = S_EVAL;
						end
					endcase
				end
			end
			S_EVAL: begin
				if (out_free) begin
					if (hit) begin
						acc_set_d = set_of(cmd_q.address);
						acc_way_d = match;
					end else if (cmd_q.kind == sacl_pkg::CMD_VICTIM) begin
						acc_set_d = set_of(cmd_q.address);
						acc_way_d = '0;
					end
					if (!hit && cmd_q.kind == sacl_pkg::CMD_VICTIM && WAYS > 1) begin
						state_d = S_SCAN;
					end else if (!hit && cmd_q.kind == sacl_pkg::CMD_REFILL) begin
						tag_re  = 1'b1;
						state_d = S_REF;
					end else begin
						stamp_wr       = 1'b1;
						stamp_waddr    = acc_set_d;
						stamp_wway     = acc_way_d;
						emit           = 1'b1;
						emit_data.kind = sacl_pkg::KIND_STATUS;
						emit_data.hit  = hit;
						emit_data.last = 1'b1;
						state_d        = S_IDLE;
					end
				end
			end
			S_SCAN: begin
				if (idx_q == WAY_W'(WAYS - 1) && out_free) begin
					acc_way_d      = lru_fin;
					stamp_wr       = 1'b1;
					stamp_wway     = lru_fin;
					emit           = 1'b1;
					emit_data.kind = sacl_pkg::KIND_STATUS;
					emit_data.last = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_REF: begin
				state_d = cmd_q.dirty ? S_WB_RD : S_FIN;
			end
			S_WB_RD: begin
				data_re    = 1'b1;
				data_raddr = data_addr(acc_set_q, acc_way_q, wi_q);
				state_d    = S_WB_OUT;
			end
			S_WB_OUT: begin
				if (out_free) begin
					emit                     = 1'b1;
					emit_data.kind           = sacl_pkg::KIND_WB;
					emit_data.word_out       = data_rdata;
					emit_data.memory_address = wb_addr_q;
					state_d = (wi_q == WORD_W'(LINE_WORDS - 1)) ? S_FIN : S_WB_RD;
				end
			end
			S_FIN: begin
				if (out_free) begin
					tag_wr         = 1'b1;
					stamp_wr       = 1'b1;
					emit           = 1'b1;
					emit_data.kind = sacl_pkg::KIND_STATUS;
					emit_data.last = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_LOAD: begin
				if (out_free) begin
					emit               = 1'b1;
					emit_data.kind     = sacl_pkg::KIND_READ;
					emit_data.word_out = data_rdata;
					emit_data.last     = 1'b1;
					state_d            = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		emit_data.way = 2'(acc_way_d);
		if (emit_data.kind != sacl_pkg::KIND_STATUS) begin
			emit_data.last = (emit_data.kind != sacl_pkg::KIND_WB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			acc_set_q   <= '0;
			acc_way_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			acc_set_q <= acc_set_d;
			acc_way_q <= acc_way_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + DATA_AW'(1);
			end
			if (out_valid_q && !response_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers of the sequencer, no reset needed.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_data;
		end
		if (head_pop) begin
			cmd_q <= head.cmd;
		end
		if (state_q == S_EVAL) begin
			idx_q  <= WAY_W'(1);
			lru_q  <= '0;
			best_q <= stamp_row[0];
		end else if (state_q == S_SCAN && idx_q != WAY_W'(WAYS - 1)) begin
			idx_q <= idx_q + WAY_W'(1);
			if (cand) begin
				lru_q  <= idx_q;
				best_q <= stamp_row[idx_q];
			end
		end
		if (state_q == S_REF) begin
			wi_q      <= '0;
			wb_addr_q <= (64'(tag_row[acc_way_q][TAG_W-1:0]) << (SET_BITS + BLOCK_BITS))
				| (64'(acc_set_q) << BLOCK_BITS);
		end else if (state_q == S_WB_OUT && out_free) begin
			wi_q      <= wi_q + WORD_W'(1);
			wb_addr_q <= wb_addr_q + 64'(sacl_pkg::WORD_BYTES);
		end
	end

	assign response_valid = out_valid_q;
	assign response       = out_q;

	`SACL_ASSERT(a_no_pop_clear, (state_q == S_CLEAR) |-> !head_pop)
	`SACL_ASSERT(a_wb_not_last, (out_valid_q && out_q.kind == sacl_pkg::KIND_WB) |-> (!out_q.last && !out_q.hit))
	`SACL_ASSERT(a_other_last, (out_valid_q && out_q.kind != sacl_pkg::KIND_WB) |-> out_q.last)
	`SACL_ASSERT_NEXT(a_pop_busy, head_pop, state_q != S_IDLE || out_valid_q)

endmodule

FILE: sv/set_associative_cache_lru_unit.sv
// Set-associative cache with LRU victim choice and write-back refill. After
// reset a clearing pass zeroes every tag, stamp and data word; requests queue
// meanwhile. A plain lookup reads the set, then compares and writes the stamp;
// a victim-choosing miss adds the oldest-stamp scan; a refill miss rereads
// the tags, writes back the victim line word by word (a read and an output
// step per word) when it is dirty, then writes tag and stamp; a read reads
// the data word, then returns it; a write or fill writes the word. One command
// executes at a time; a two-entry command queue and the response register
// let request and response transfers continue meanwhile.
// Depends on sacl_pkg, sacl_front and sacl_back.
`timescale 1ns / 1ps

module set_associative_cache_lru_unit #(
	parameter int SET_BITS   = sacl_pkg::SET_BITS_DEF,
	parameter int WAYS       = sacl_pkg::WAYS_DEF,
	parameter int BLOCK_BITS = sacl_pkg::BLOCK_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           request_valid,
	output logic           request_stall,
	input  sacl_pkg::in_t  request,
	output logic           response_valid,
	input  logic           response_stall,
	output sacl_pkg::out_t response
);

	sacl_pkg::qhead_t head;
	logic             head_pop;

	sacl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.head          (head),
		.head_pop      (head_pop)
	);

	sacl_back #(
		.SET_BITS   (SET_BITS),
		.WAYS       (WAYS),
		.BLOCK_BITS (BLOCK_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.head_pop       (head_pop),
		.response_valid (response_valid),
		.response_stall (response_stall),
		.response       (response)
	);

endmodule
